/* rtl/core/mf33_pkg.sv */
// Shared constants, types and the divide-by-nine rounding function of the 3x3 mean filter.
package mf33_pkg;

  // Geometry limits
  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_CHANNELS = 4;
  localparam int STORE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int X_W          = $clog2(MAX_WIDTH);
  localparam int C_W          = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Port widths
  localparam int WIDTH_REG_W  = 12;
  localparam int CHAN_REG_W   = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;
  localparam int SAMPLE_W     = 8;

  // Arithmetic widths: a column sum of three samples, a sum of nine
  localparam int COLSUM_W     = 10;
  localparam int SUM_W        = 12;
  localparam int BIASED_W     = SUM_W + 1;
  localparam int FACTOR_W     = 13;
  localparam int PROD_W       = BIASED_W + FACTOR_W;
  localparam int DIV9_SHIFT   = 16;
  localparam int QUOT_W       = PROD_W - DIV9_SHIFT;

  localparam logic [BIASED_W-1:0] ROUND_BIAS  = BIASED_W'(5);
  localparam logic [FACTOR_W-1:0] DIV9_FACTOR = FACTOR_W'(7282);
  localparam logic [QUOT_W-1:0]   MEAN_MAX    = QUOT_W'(255);

  // Register reset values
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_CHANNELS = 1;

  // Result queue
  localparam int Q_DEPTH = 3;
  localparam int Q_CNT_W = 2;
  localparam int NRES_W  = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_CHANNEL_COUNT = 2'd1
  } cfg_idx_t;

  // Input item kinds
  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_DRAIN  = 1'b1
  } req_t;

  // One result item
  typedef struct packed {
    logic [SAMPLE_W-1:0] mean_value;
    logic                last_in_run;
    logic                frame_end;
  } result_t;

  // Results handed from the compute stage to the result queue
  typedef struct packed {
    logic [NRES_W-1:0] cnt;
    result_t           res0;
    result_t           res1;
  } q_push_t;

  // Rounded mean of nine samples: ((sum + 5) * 7282) >> 16, clamped to 255
  function automatic logic [SAMPLE_W-1:0] mean9(input logic [SUM_W-1:0] sum);
    logic [BIASED_W-1:0] biased;
    logic [PROD_W-1:0]   prod;
    logic [QUOT_W-1:0]   quot;
    biased = {1'b0, sum} + ROUND_BIAS;
    prod   = PROD_W'(biased) * PROD_W'(DIV9_FACTOR);
    quot   = prod[PROD_W-1:DIV9_SHIFT];
    return (quot > MEAN_MAX) ? SAMPLE_W'(MEAN_MAX) : quot[SAMPLE_W-1:0];
  endfunction

endpackage

/* rtl/core/mf33_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
module mf33_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_a_r;
  logic [WIDTH-1:0] rd_data_b_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read ports, hold data while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a_r <= mem_r[rd_addr_a];
      rd_data_b_r <= mem_r[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

/* rtl/core/mf33_queue.sv */
// Three-entry result queue that takes up to two results per cycle while it has room, and feeds the output port.
module mf33_queue
  import mf33_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t push,
  input  logic    pop,
  output logic    room,
  output logic    head_valid,
  output result_t head
);

  result_t            ent_r   [Q_DEPTH];
  result_t            ent_nxt [Q_DEPTH];
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_CNT_W-1:0] cnt_nxt;
  logic [Q_CNT_W-1:0] base;

  // Shift out the head on pop, then append the new results behind what remains
  always_comb begin
    base = cnt_r - Q_CNT_W'(pop);
    for (int i = 0; i < Q_DEPTH; i++) begin
      if (pop && (i < Q_DEPTH - 1)) begin
        ent_nxt[i] = ent_r[i+1];
      end else begin
        ent_nxt[i] = ent_r[i];
      end
      if ((push.cnt != '0) && (Q_CNT_W'(i) == base)) begin
        ent_nxt[i] = push.res0;
      end
      if ((push.cnt == NRES_W'(2)) && (Q_CNT_W'(i) == base + Q_CNT_W'(1))) begin
        ent_nxt[i] = push.res1;
      end
    end
    cnt_nxt = base + Q_CNT_W'(push.cnt);
  end

  // Hold payload, count entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  assign room       = (cnt_r <= Q_CNT_W'(1));
  assign head_valid = (cnt_r != '0);
  assign head       = ent_r[0];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue count beyond depth");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != '0) |-> room)
    else $error("results pushed without room for two");

endmodule

/* rtl/core/mean_filter_3x3.sv */
// Top level of the streaming 3x3 mean filter with edge replication and line stores.
//
//  port group | direction | handshake          | payload
//  -----------+-----------+--------------------+-------------------------------------------
//  in_        | in        | in_valid/in_ready  | in_req_type, in_sample
//  out_       | out       | out_valid/out_ready| out_mean_value, out_last_in_run, out_frame_end
//  cfg_       | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (cfg_ready always high)
//
//  One item per cycle while in_ready is high. The line stores are read at the accepting edge
//  into the read stage, and the compute stage pushes the results into the result queue, whose
//  head drives out_. A sample of the last pixel of a row gives two results, and the queue takes
//  an item's results only with room for two, so in_ready drops while two results wait in the
//  three-entry result queue and the waiting item has a result, as under a stall on out_.
//  rst_n is synchronous and active low; the line stores are not cleared and need no sweep.
//  A write to either configuration register restarts the image at its first row.
module mean_filter_3x3
  import mf33_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_mean_value,
  output logic                  out_last_in_run,
  output logic                  out_frame_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Geometry
  logic [X_W-1:0]         w_last_r, w_last_nxt;
  logic [C_W-1:0]         ch_last_r, ch_last_nxt;
  logic [WIDTH_REG_W-1:0] wnum;
  logic [CHAN_REG_W-1:0]  cnum;
  logic                   cfg_wr;

  // Stream position
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [X_W-1:0]    x_r, x_nxt;
  logic [C_W-1:0]    c_r, c_nxt;
  logic [1:0]        rows_r, rows_nxt;
  logic [ADDR_W-1:0] dpos_r, dpos_nxt;
  logic [X_W-1:0]    dx_r, dx_nxt;
  logic [C_W-1:0]    dc_r, dc_nxt;

  logic in_acc, is_drain, drain_ok, row_end, drain_final, take;

  // Read stage
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_drain_r, s1_first_r, s1_x0_r, s1_lastpx_r, s1_final_r;
  logic [C_W-1:0]      s1_c_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  logic                byp_a_r, byp_b_r;
  logic [SAMPLE_W-1:0] byp_old_r, byp_new_r;

  logic [ADDR_W-1:0]   rd_addr_a, rd_addr_b;
  logic [SAMPLE_W-1:0] old_a, old_b, new_a, new_b;

  // Compute stage
  logic [COLSUM_W-1:0] win0_r [MAX_CHANNELS];
  logic [COLSUM_W-1:0] win1_r [MAX_CHANNELS];
  logic [SAMPLE_W-1:0] o_a, n_a, o_b, n_b;
  logic [COLSUM_W-1:0] cs, mid, right_cs, left_cs, w0, w1;
  logic [SUM_W-1:0]    sum0, sum1;
  logic [NRES_W-1:0]   nres;
  logic                wr_en, s1_adv, q_room;
  logic [SAMPLE_W-1:0] wr_old, wr_new;
  q_push_t             push;
  result_t             head;

  // ---------------------------------------------------------------- configuration
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && ((cfg_index == CFG_IMAGE_WIDTH) ||
                                   (cfg_index == CFG_CHANNEL_COUNT));
  assign wnum      = cfg_data[WIDTH_REG_W-1:0];
  assign cnum      = cfg_data[CHAN_REG_W-1:0];

  // Saturate the registers and keep the last pixel and channel index
  always_comb begin
    w_last_nxt  = w_last_r;
    ch_last_nxt = ch_last_r;
    if (cfg_valid && (cfg_index == CFG_IMAGE_WIDTH)) begin
      if (wnum < WIDTH_REG_W'(2)) begin
        w_last_nxt = X_W'(1);
      end else if (32'(wnum) > 32'(MAX_WIDTH)) begin
        w_last_nxt = X_W'(MAX_WIDTH - 1);
      end else begin
        w_last_nxt = X_W'(wnum - WIDTH_REG_W'(1));
      end
    end
    if (cfg_valid && (cfg_index == CFG_CHANNEL_COUNT)) begin
      if (cnum == '0) begin
        ch_last_nxt = '0;
      end else if (32'(cnum) > 32'(MAX_CHANNELS)) begin
        ch_last_nxt = C_W'(MAX_CHANNELS - 1);
      end else begin
        ch_last_nxt = C_W'(cnum - CHAN_REG_W'(1));
      end
    end
  end

  // ---------------------------------------------------------------- position control
  assign in_acc      = in_valid && in_ready;
  assign is_drain    = (in_req_type == REQ_DRAIN);
  assign drain_ok    = (rows_r != 2'd0) && (pos_r == '0);
  assign row_end     = (x_r == w_last_r) && (c_r == ch_last_r);
  assign drain_final = (dx_r == w_last_r) && (dc_r == ch_last_r);
  assign take        = in_acc && (!is_drain || drain_ok);

  // Advance sample and drain positions; restart on a register write or a finished drain
  always_comb begin
    pos_nxt  = pos_r;
    x_nxt    = x_r;
    c_nxt    = c_r;
    rows_nxt = rows_r;
    dpos_nxt = dpos_r;
    dx_nxt   = dx_r;
    dc_nxt   = dc_r;
    if (cfg_wr || (in_acc && is_drain && drain_ok && drain_final)) begin
      pos_nxt  = '0;
      x_nxt    = '0;
      c_nxt    = '0;
      rows_nxt = 2'd0;
      dpos_nxt = '0;
      dx_nxt   = '0;
      dc_nxt   = '0;
    end else if (in_acc && !is_drain) begin
      dpos_nxt = '0;
      dx_nxt   = '0;
      dc_nxt   = '0;
      if (row_end) begin
        pos_nxt = '0;
        x_nxt   = '0;
        c_nxt   = '0;
        if (rows_r != 2'd2) begin
          rows_nxt = rows_r + 2'd1;
        end
      end else begin
        pos_nxt = pos_r + ADDR_W'(1);
        if (c_r == ch_last_r) begin
          c_nxt = '0;
          x_nxt = x_r + X_W'(1);
        end else begin
          c_nxt = c_r + C_W'(1);
        end
      end
    end else if (in_acc && is_drain && drain_ok) begin
      dpos_nxt = dpos_r + ADDR_W'(1);
      if (dc_r == ch_last_r) begin
        dc_nxt = '0;
        dx_nxt = dx_r + X_W'(1);
      end else begin
        dc_nxt = dc_r + C_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r  <= X_W'(RESET_WIDTH - 1);
      ch_last_r <= C_W'(RESET_CHANNELS - 1);
      pos_r     <= '0;
      x_r       <= '0;
      c_r       <= '0;
      rows_r    <= 2'd0;
      dpos_r    <= '0;
      dx_r      <= '0;
      dc_r      <= '0;
    end else begin
      w_last_r  <= w_last_nxt;
      ch_last_r <= ch_last_nxt;
      pos_r     <= pos_nxt;
      x_r       <= x_nxt;
      c_r       <= c_nxt;
      rows_r    <= rows_nxt;
      dpos_r    <= dpos_nxt;
      dx_r      <= dx_nxt;
      dc_r      <= dc_nxt;
    end
  end

  // ---------------------------------------------------------------- line store read
  // Port A reads the item's own position, port B the next pixel of the drained row
  assign rd_addr_a = is_drain ? dpos_r : pos_r;
  assign rd_addr_b = dpos_r + ADDR_W'(ch_last_r) + ADDR_W'(1);

  mf33_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_older_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (s1_addr_r),
    .wr_data   (wr_old),
    .rd_en     (take),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (old_a),
    .rd_data_b (old_b)
  );

  mf33_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_newer_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (s1_addr_r),
    .wr_data   (wr_new),
    .rd_en     (take),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (new_a),
    .rd_data_b (new_b)
  );

  // Read stage valid: load on take, drop on advance
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Capture the item, and forward a store write that lands with this read
  always_ff @(posedge clk) begin
    if (take) begin
      s1_drain_r  <= is_drain;
      s1_first_r  <= (rows_r == 2'd0);
      s1_x0_r     <= is_drain ? (dx_r == '0) : (x_r == '0);
      s1_lastpx_r <= is_drain ? (dx_r == w_last_r) : (x_r == w_last_r);
      s1_final_r  <= drain_final;
      s1_c_r      <= is_drain ? dc_r : c_r;
      s1_sample_r <= in_sample;
      s1_addr_r   <= rd_addr_a;
      byp_a_r     <= wr_en && (rd_addr_a == s1_addr_r);
      byp_b_r     <= wr_en && (rd_addr_b == s1_addr_r);
      byp_old_r   <= wr_old;
      byp_new_r   <= wr_new;
    end
  end

  // ---------------------------------------------------------------- compute stage
  always_comb begin
    o_a = byp_a_r ? byp_old_r : old_a;
    n_a = byp_a_r ? byp_new_r : new_a;
    o_b = byp_b_r ? byp_old_r : old_b;
    n_b = byp_b_r ? byp_new_r : new_b;
    w0  = win0_r[s1_c_r];
    w1  = win1_r[s1_c_r];

    // Vertical sums: three rows for a sample, bottom row replicated for a drain
    cs       = COLSUM_W'(o_a) + COLSUM_W'(n_a) + COLSUM_W'(s1_sample_r);
    mid      = COLSUM_W'(o_a) + (COLSUM_W'(n_a) << 1);
    right_cs = s1_lastpx_r ? mid : (COLSUM_W'(o_b) + (COLSUM_W'(n_b) << 1));
    left_cs  = s1_x0_r ? mid : w1;

    // Horizontal sums, right edge replicated for the second result
    if (s1_drain_r) begin
      sum0 = SUM_W'(left_cs) + SUM_W'(mid) + SUM_W'(right_cs);
    end else begin
      sum0 = SUM_W'(w0) + SUM_W'(w1) + SUM_W'(cs);
    end
    sum1 = SUM_W'(w1) + (SUM_W'(cs) << 1);

    // Results per item
    if (s1_drain_r) begin
      nres = NRES_W'(1);
    end else if (s1_first_r || s1_x0_r) begin
      nres = NRES_W'(0);
    end else if (s1_lastpx_r) begin
      nres = NRES_W'(2);
    end else begin
      nres = NRES_W'(1);
    end

    s1_adv = s1_valid_r && ((nres == '0) || q_room);

    // Shift the line stores down by one row; the first row fills both
    wr_en  = s1_adv && !s1_drain_r;
    wr_old = s1_first_r ? s1_sample_r : n_a;
    wr_new = s1_sample_r;

    push.cnt              = s1_adv ? nres : NRES_W'(0);
    push.res0.mean_value  = mean9(sum0);
    push.res0.last_in_run = !(!s1_drain_r && s1_lastpx_r);
    push.res0.frame_end   = s1_drain_r && s1_final_r;
    push.res1.mean_value  = mean9(sum1);
    push.res1.last_in_run = 1'b1;
    push.res1.frame_end   = 1'b0;
  end

  // Advance the per-channel column sum window
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_drain_r) begin
        win1_r[s1_c_r] <= mid;
      end else if (!s1_first_r) begin
        win0_r[s1_c_r] <= s1_x0_r ? cs : w1;
        win1_r[s1_c_r] <= cs;
      end
    end
  end

  assign in_ready = !s1_valid_r || s1_adv;

  // ---------------------------------------------------------------- result queue
  mf33_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_valid && out_ready),
    .room       (q_room),
    .head_valid (out_valid),
    .head       (head)
  );

  assign out_mean_value  = head.mean_value;
  assign out_last_in_run = head.last_in_run;
  assign out_frame_end   = head.frame_end;

  // ---------------------------------------------------------------- assertions
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (x_r <= w_last_r) && (c_r <= ch_last_r))
    else $error("pixel or channel counter beyond row geometry");

  a_drain_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_drain && drain_ok && drain_final) |=> (pos_r == '0) && (rows_r == 2'd0))
    else $error("image not restarted after final drain item");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && !q_room))
    else $error("input held without a waiting item and a full queue");

  a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> out_last_in_run)
    else $error("frame end on a result that is not the last of its item");

endmodule

/* verif/tb_mean_filter_3x3.sv */
// Self-checking testbench for mean_filter_3x3: directed edge cases, random frames, scoreboard.
`timescale 1ns / 100ps

module tb_mean_filter_3x3;
  import mf33_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 1100;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned PRINT_CAP     = 200;
  localparam int unsigned MEAN_CEIL     = 255;
  localparam int          TIMEOUT_NS    = 5_000_000;

  // Register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // How a frame is closed after its rows
  typedef enum {CLOSE_DRAIN, CLOSE_RESUME, CLOSE_CUT} frame_close_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_req_type;
  logic [SAMPLE_W-1:0]   in_sample;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [SAMPLE_W-1:0]   out_mean_value;
  logic                  out_last_in_run;
  logic                  out_frame_end;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: registers, line stores, column sums and stream positions
  logic [WIDTH_REG_W-1:0] cur_width;
  logic [CHAN_REG_W-1:0]  cur_chans;
  bit [SAMPLE_W-1:0]      row_old [STORE_DEPTH];
  bit [SAMPLE_W-1:0]      row_new [STORE_DEPTH];
  int unsigned            col_win [MAX_CHANNELS][2];
  int unsigned            next_pos;
  int unsigned            rows_done;
  int unsigned            drain_pos;

  result_t     mean_queue[$];
  result_t     head_mean;
  int unsigned fail_count    = 0;
  int unsigned live_items    = 0;
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned noise_pct     = 0;
  int unsigned stall_left    = 0;

  mean_filter_3x3 dut (.*);

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned eff_width();
    if (cur_width < 2) return 2;
    if (cur_width > MAX_WIDTH) return MAX_WIDTH;
    return cur_width;
  endfunction

  function automatic int unsigned eff_chans();
    if (cur_chans < 1) return 1;
    if (cur_chans > MAX_CHANNELS) return MAX_CHANNELS;
    return cur_chans;
  endfunction

  function automatic void restart_image();
    foreach (col_win[i, j]) col_win[i][j] = 0;
    next_pos  = 0;
    rows_done = 0;
    drain_pos = 0;
  endfunction

  // Weighted column sum of the final row: the row below repeats the newest one
  function automatic int unsigned stored_colsum(int unsigned a);
    return row_old[a] + 2 * row_new[a];
  endfunction

  // Round a nine-sample sum to its mean and queue the result
  function automatic void queue_mean(int unsigned nine_sum, bit last, bit fend);
    int unsigned scaled;
    result_t     r;
    scaled = ((nine_sum + ROUND_BIAS) * DIV9_FACTOR) >> DIV9_SHIFT;
    r.mean_value  = (scaled > MEAN_CEIL) ? SAMPLE_W'(MEAN_CEIL) : SAMPLE_W'(scaled);
    r.last_in_run = last;
    r.frame_end   = fend;
    mean_queue.push_back(r);
  endfunction

  // Queue the results of one accepted item; return 0 when the block ignores it
  function automatic bit predict_means(req_t kind, logic [SAMPLE_W-1:0] s);
    int unsigned w, ch, row_len, d, x, c, p, left, mid, right, cs, first;
    w       = eff_width();
    ch      = eff_chans();
    row_len = w * ch;
    if (kind == REQ_DRAIN) begin
      // drop a drain before a full row or inside a row
      if (rows_done == 0 || next_pos != 0) return 1'b0;
      d     = (drain_pos >= row_len) ? 0 : drain_pos;
      x     = d / ch;
      mid   = stored_colsum(d);
      left  = (x > 0) ? stored_colsum(d - ch) : mid;
      right = (x + 1 < w) ? stored_colsum(d + ch) : mid;
      if (d + 1 >= row_len) begin
        queue_mean(left + mid + right, 1'b1, 1'b1);
        restart_image();
      end else begin
        queue_mean(left + mid + right, 1'b1, 1'b0);
        drain_pos = d + 1;
      end
      return 1'b1;
    end
    // a sample abandons any drain in progress
    drain_pos = 0;
    p = (next_pos >= row_len) ? 0 : next_pos;
    x = p / ch;
    c = p % ch;
    if (rows_done == 0) begin
      row_old[p] = s;
      row_new[p] = s;
    end else begin
      cs = row_old[p] + row_new[p] + s;
      row_old[p] = row_new[p];
      row_new[p] = s;
      if (x == 0) begin
        col_win[c][0] = cs;
        col_win[c][1] = cs;
      end else begin
        first = col_win[c][0] + col_win[c][1] + cs;
        col_win[c][0] = col_win[c][1];
        col_win[c][1] = cs;
        if (x + 1 >= w) begin
          queue_mean(first, 1'b0, 1'b0);
          queue_mean(col_win[c][0] + 2 * col_win[c][1], 1'b1, 1'b0);
        end else begin
          queue_mean(first, 1'b1, 1'b0);
        end
      end
    end
    if (p + 1 >= row_len) begin
      next_pos = 0;
      if (rows_done < 2) rows_done++;
    end else begin
      next_pos = p + 1;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- result side

  // Stall the result channel in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      stall_left <= $urandom_range(1, 19);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest queued mean
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (mean_queue.size() == 0) begin
        if (fail_count < PRINT_CAP)
          $display("%0t: unexpected result mean=%0d last=%0b end=%0b", $time,
                   out_mean_value, out_last_in_run, out_frame_end);
        fail_count++;
      end else begin
        head_mean = mean_queue.pop_front();
        if (out_mean_value !== head_mean.mean_value ||
            out_last_in_run !== head_mean.last_in_run ||
            out_frame_end !== head_mean.frame_end) begin
          if (fail_count < PRINT_CAP)
            $display("%0t: expected mean=%0d last=%0b end=%0b, got mean=%0d last=%0b end=%0b",
                     $time, head_mean.mean_value, head_mean.last_in_run,
                     head_mean.frame_end, out_mean_value, out_last_in_run, out_frame_end);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Send one item, sometimes with a random gap ahead of it
  task automatic send_item(req_t kind, logic [SAMPLE_W-1:0] s);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_sample   <= s;
    do @(posedge clk); while (!in_ready);
    if (predict_means(kind, s)) live_items++;
  endtask

  // Hold the sender until every queued mean has arrived and the pipe is empty
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (mean_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) begin
      cur_width = data[WIDTH_REG_W-1:0];
      restart_image();
    end else if (idx == CFG_CHANNEL_COUNT) begin
      cur_chans = data[CHAN_REG_W-1:0];
      restart_image();
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Stream one row of samples, with stray drains mixed in
  task automatic send_row(int unsigned row_len);
    for (int unsigned p = 0; p < row_len; p++) begin
      if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct)
        send_item(REQ_DRAIN, SAMPLE_W'($urandom_range(0, 255)));
      send_item(REQ_SAMPLE, pick_sample());
    end
  endtask

  task automatic send_drains(int unsigned n);
    repeat (n) send_item(REQ_DRAIN, SAMPLE_W'($urandom_range(0, 255)));
  endtask

  task automatic run_frame(int unsigned rows, frame_close_t close_kind);
    int unsigned row_len;
    row_len = eff_width() * eff_chans();
    for (int unsigned r = 0; r < rows; r++) begin
      if (in_idle_pct != 0 && $urandom_range(0, 49) == 0) wait_quiet();
      send_row(row_len);
    end
    case (close_kind)
      CLOSE_DRAIN: send_drains(row_len);
      CLOSE_RESUME: begin
        // break off the drain with one more row, then drain again
        send_drains($urandom_range(1, row_len - 1));
        send_row(row_len);
        send_drains(row_len);
      end
      default: repeat ($urandom_range(1, row_len - 1)) send_item(REQ_SAMPLE, pick_sample());
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  // Default geometry straight out of reset: 640 pixels, one channel
  task automatic test_reset_defaults();
    in_idle_pct   = 10;
    out_stall_pct = 10;
    send_item(REQ_DRAIN, 8'hA5);
    send_row(eff_width() * eff_chans());
    repeat (3) send_item(REQ_SAMPLE, pick_sample());
  endtask

  task automatic test_directed_edges();
    in_idle_pct   = 20;
    out_stall_pct = 20;
    write_reg(CFG_IMAGE_WIDTH, 12'd2);
    write_reg(CFG_CHANNEL_COUNT, 12'd1);
    // drain before any row
    send_item(REQ_DRAIN, 8'h00);
    // full-scale rows give the largest sum
    send_item(REQ_SAMPLE, 8'hFF);
    send_item(REQ_SAMPLE, 8'hFF);
    // spare register index leaves the image running
    write_reg(CFG_SPARE_LO, 12'hFFF);
    send_item(REQ_SAMPLE, 8'hFF);
    send_item(REQ_SAMPLE, 8'hFF);
    // drain inside a row
    send_item(REQ_SAMPLE, 8'h00);
    send_item(REQ_DRAIN, 8'hFF);
    send_item(REQ_SAMPLE, 8'h00);
    // sample in the middle of a drain
    send_item(REQ_DRAIN, 8'h00);
    send_item(REQ_SAMPLE, 8'h80);
    send_item(REQ_SAMPLE, 8'h7F);
    send_item(REQ_DRAIN, 8'h00);
    send_item(REQ_DRAIN, 8'h00);
    // single-row image, width below range
    write_reg(CFG_IMAGE_WIDTH, 12'd0);
    write_reg(CFG_SPARE_HI, 12'h000);
    send_item(REQ_SAMPLE, 8'h00);
    send_item(REQ_SAMPLE, 8'hFF);
    send_item(REQ_DRAIN, 8'h55);
    send_item(REQ_DRAIN, 8'hAA);
    // drain after the image has ended
    send_item(REQ_DRAIN, 8'h00);
  endtask

  task automatic test_register_saturation();
    in_idle_pct   = 10;
    out_stall_pct = 10;
    write_reg(CFG_CHANNEL_COUNT, 12'd7);
    write_reg(CFG_IMAGE_WIDTH, 12'd3);
    run_frame(2, CLOSE_DRAIN);
    write_reg(CFG_IMAGE_WIDTH, 12'd1);
    write_reg(CFG_CHANNEL_COUNT, 12'd0);
    run_frame(2, CLOSE_DRAIN);
  endtask

  task automatic test_random_frames();
    int unsigned  pick, w_reg, ch_reg;
    frame_close_t close_kind;
    live_items = 0;
    noise_pct  = 2;
    while (live_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 2);
      in_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 8 : 30;
      pick = $urandom_range(0, 2);
      out_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 8 : 30;
      pick = $urandom_range(0, 99);
      w_reg  = (pick < 8) ? $urandom_range(0, 1) :
               (pick < 80) ? $urandom_range(2, 9) : $urandom_range(10, 48);
      ch_reg = $urandom_range(0, 7);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w_reg));
      end else if (pick < 55) begin
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w_reg));
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(ch_reg));
      end else begin
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(ch_reg));
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w_reg));
      end
      pick = $urandom_range(0, 99);
      close_kind = (pick < 70) ? CLOSE_DRAIN : (pick < 85) ? CLOSE_RESUME : CLOSE_CUT;
      run_frame($urandom_range(1, 4), close_kind);
      if ($urandom_range(0, 9) == 0) send_item(REQ_DRAIN, pick_sample());
    end
    noise_pct = 0;
  endtask

  // Back-to-back items with an always-ready receiver
  task automatic test_full_rate_tail();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    write_reg(CFG_CHANNEL_COUNT, 12'd4);
    write_reg(CFG_IMAGE_WIDTH, 12'd6);
    run_frame(3, CLOSE_DRAIN);
    write_reg(CFG_CHANNEL_COUNT, 12'd1);
    write_reg(CFG_IMAGE_WIDTH, 12'd11);
    run_frame(3, CLOSE_DRAIN);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_SAMPLE;
    in_sample   <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_IMAGE_WIDTH;
    cfg_data    <= '0;
    cur_width = RESET_WIDTH;
    cur_chans = RESET_CHANNELS;
    restart_image();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_directed_edges();
    test_register_saturation();
    test_random_frames();
    test_full_rate_tail();

    // Let the last results drain out
    in_valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && mean_queue.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mean_queue.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, mean_queue.size());
      fail_count++;
    end
    if (fail_count == 0) $display("[mean_filter_3x3] OK");
    else $display("[mean_filter_3x3] ERROR");
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("[mean_filter_3x3] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/mf33_pkg.sv
rtl/core/mf33_ram.sv
rtl/core/mf33_queue.sv
rtl/core/mean_filter_3x3.sv
verif/tb_mean_filter_3x3.sv
